/* rtl/bals_pkg.sv */
package bals_pkg;

  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_ALIGN = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_ACCESS,
    S_LOAD_CAP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } mem_req_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] rdata;
    logic [1:0]  status;
  } res_t;

endpackage

/* rtl/byte_addressed_load_store_memory.sv */
// Sequence: an accepted request is checked first; a failed access goes straight to the result,
//   a store writes its n bytes in turn and a load alternates a read and a capture for each of
//   its n bytes; one byte moves per memory access of the sequencer.
// Throughput: one request at a time; in_tready returns high once the result register
//   is loaded.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to all 65536
//   bytes, one per cycle, and in_tready stays low until the pass ends.
module byte_addressed_load_store_memory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // byte_address[31:0], write_data[63:32]
  input  logic [2:0]  in_tuser,   // req_type[0], access_size[2:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // read_data[31:0]
  output logic [1:0]  out_tuser   // status[1:0]
);
  import bals_pkg::*;

  mem_req_t    mem_req;
  logic [7:0]  mem_rd_data;
  res_t        res;
  logic        res_take;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic [1:0]  out_status_r;

  assign res_take = !out_valid_r || out_tready;

  bals_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  bals_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .req_type     (in_tuser[0]),
    .access_size  (in_tuser[2:1]),
    .byte_address (in_tdata[31:0]),
    .write_data   (in_tdata[63:32]),
    .res_take     (res_take),
    .res          (res),
    .mem_req      (mem_req),
    .mem_rd_data  (mem_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res.valid) begin
      out_data_r   <= res.rdata;
      out_status_r <= res.status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

/* rtl/bals_mem.sv */
module bals_mem (
  input  logic              clk,
  input  bals_pkg::mem_req_t req,
  output logic [7:0]        rd_data
);
  import bals_pkg::*;

  logic [7:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.addr];
    end
  end

endmodule

/* rtl/bals_seq.sv */
module bals_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  input  logic [1:0]         access_size,
  input  logic [31:0]        byte_address,
  input  logic [31:0]        write_data,
  input  logic               res_take,
  output bals_pkg::res_t     res,
  output bals_pkg::mem_req_t mem_req,
  input  logic [7:0]         mem_rd_data
);
  import bals_pkg::*;

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [31:0]       addr_r, addr_nxt;
  logic [31:0]       wdata_r, wdata_nxt;
  logic              store_r, store_nxt;
  logic [1:0]        mask_r, mask_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [31:0]       rdata_r, rdata_nxt;
  logic [1:0]        status_r, status_nxt;

  logic [ADDR_W:0]   cur_addr;
  logic              cur_out;
  logic              last_byte;
  logic              addr_range_bad;
  logic              accept;
  logic [1:0]        size_mask;

  assign accept         = in_valid && in_ready;
  assign cur_addr       = {1'b0, addr_r[ADDR_W-1:0]} + {{(ADDR_W-1){1'b0}}, idx_r};
  assign cur_out        = cur_addr >= (ADDR_W+1)'(MEM_BYTES);
  assign last_byte      = idx_r == mask_r;
  assign addr_range_bad = {1'b0, addr_r} >= 33'(MEM_BYTES);

  always_comb begin
    unique case (access_size)
      SZ_BYTE: size_mask = 2'd0;
      SZ_HALF: size_mask = 2'd1;
      default: size_mask = 2'd3;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(MEM_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (addr_range_bad || ((addr_r[1:0] & mask_r) != 2'd0)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_ACCESS;
        end
      end
      S_ACCESS: begin
        if (cur_out) begin
          state_nxt = S_DONE;
        end else if (!store_r) begin
          state_nxt = S_LOAD_CAP;
        end else if (last_byte) begin
          state_nxt = S_DONE;
        end
      end
      S_LOAD_CAP: begin
        state_nxt = last_byte ? S_DONE : S_ACCESS;
      end
      S_DONE: begin
        if (res_take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    addr_nxt      = addr_r;
    wdata_nxt     = wdata_r;
    store_nxt     = store_r;
    mask_nxt      = mask_r;
    idx_nxt       = idx_r;
    rdata_nxt     = rdata_r;
    status_nxt    = status_r;
    in_ready      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.re    = 1'b0;
    mem_req.addr  = cur_addr[ADDR_W-1:0];
    mem_req.wdata = wdata_r[8*idx_r +: 8];
    res.valid     = 1'b0;
    res.rdata     = rdata_r;
    res.status    = status_r;
    unique case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.addr  = clr_cnt_r;
        mem_req.wdata = 8'd0;
        clr_cnt_nxt   = clr_cnt_r + ADDR_W'(1);
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          addr_nxt   = byte_address;
          wdata_nxt  = write_data;
          store_nxt  = req_type == REQ_STORE;
          mask_nxt   = size_mask;
          idx_nxt    = 2'd0;
          rdata_nxt  = 32'd0;
          status_nxt = ST_OK;
        end
      end
      S_CHECK: begin
        if (addr_range_bad) begin
          status_nxt = ST_RANGE;
        end else if ((addr_r[1:0] & mask_r) != 2'd0) begin
          status_nxt = ST_ALIGN;
        end
      end
      S_ACCESS: begin
        if (!cur_out) begin
          mem_req.we = store_r;
          mem_req.re = !store_r;
          if (store_r && !last_byte) idx_nxt = idx_r + 2'd1;
        end
      end
      S_LOAD_CAP: begin
        rdata_nxt[8*idx_r +: 8] = mem_rd_data;
        if (!last_byte) idx_nxt = idx_r + 2'd1;
      end
      S_DONE: begin
        res.valid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r   <= addr_nxt;
    wdata_r  <= wdata_nxt;
    store_r  <= store_nxt;
    mask_r   <= mask_nxt;
    idx_r    <= idx_nxt;
    rdata_r  <= rdata_nxt;
    status_r <= status_nxt;
  end

endmodule

/* rtl/bals_checker.sv */
module bals_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import bals_pkg::*;

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("outputs active right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while another is in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> out_tdata == 32'd0)
    else $error("failed access returned nonzero data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind byte_addressed_load_store_memory bals_checker u_bals_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* sim/tb_byte_addressed_load_store_memory.sv */
`timescale 1ns / 1ps

module tb_byte_addressed_load_store_memory;

  import bals_pkg::*;

  localparam logic [1:0] SZ_WORD_ALT = 2'd3;
  localparam logic       TYPED       = 1'b1;
  localparam logic       PREDICTED   = 1'b0;
  localparam int unsigned PHASE_REQS  = 400;
  localparam int unsigned STALL_LIMIT = 200000;

  typedef struct packed {
    logic        req;
    logic [1:0]  sz;
    logic [31:0] addr;
    logic [31:0] wdata;
    logic        typed;
    logic [1:0]  typed_st;
  } access_t;

  typedef struct packed {
    logic [31:0] rdata;
    logic [1:0]  st;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  access_t        cur_req = '0;
  access_t        dir_reqs[$];
  access_result_t pending_results[$];
  logic [7:0]     mem_image [MEM_BYTES];
  int unsigned    send_idle_pct = 0;
  int unsigned    rcv_stall_pct = 0;
  int unsigned    fail_count = 0;
  int unsigned    stall_cycles = 0;

  byte_addressed_load_store_memory DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int unsigned size_bytes(input logic [1:0] sz);
    case (sz)
      SZ_BYTE: return 1;
      SZ_HALF: return 2;
      default: return 4;
    endcase
  endfunction

  function automatic access_result_t apply_access(input access_t a);
    access_result_t r;
    int unsigned nb;
    nb = size_bytes(a.sz);
    r.rdata = '0;
    if (a.addr >= MEM_BYTES) begin
      r.st = ST_RANGE;
    end else if ((a.addr & (nb - 1)) != 0) begin
      r.st = ST_ALIGN;
    end else begin
      r.st = ST_OK;
      for (int i = 0; i < nb; i++) begin
        if (a.addr + i < MEM_BYTES) begin
          if (a.req == REQ_STORE) begin
            mem_image[a.addr + i] = a.wdata[8*i +: 8];
          end else begin
            r.rdata[8*i +: 8] = mem_image[a.addr + i];
          end
        end
      end
    end
    return r;
  endfunction

  function automatic access_t random_access();
    access_t a;
    int unsigned k, nb;
    logic [31:0] base;
    a.typed = PREDICTED;
    a.typed_st = ST_OK;
    a.req = ($urandom_range(1) != 0) ? REQ_STORE : REQ_LOAD;
    a.wdata = $urandom;
    case ($urandom_range(9))
      0:       a.sz = SZ_WORD_ALT;
      1, 2, 3: a.sz = SZ_BYTE;
      4, 5, 6: a.sz = SZ_HALF;
      default: a.sz = SZ_WORD;
    endcase
    nb = size_bytes(a.sz);
    base = ($urandom_range(1) != 0) ? MEM_BYTES - 256 : 0;
    k = $urandom_range(99);
    if (k < 70) begin
      a.addr = (base + $urandom_range(255)) & ~(nb - 1);
    end else if (k < 80) begin
      a.addr = $urandom_range(MEM_BYTES - 1) & ~(nb - 1);
    end else if (k < 90) begin
      if (nb == 1) begin
        a.sz = SZ_HALF;
        nb = 2;
      end
      a.addr = ((base + $urandom_range(255)) & ~(nb - 1)) | $urandom_range(nb - 1, 1);
    end else begin
      a.addr = $urandom | (32'h1 << $urandom_range(31, 16));
    end
    return a;
  endfunction

  task automatic issue(input access_t a);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {a.wdata, a.addr};
    in_tuser  <= {a.sz, a.req};
    cur_req   <= a;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    access_result_t pred, want;
    logic moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        moved = 1'b1;
        pred = apply_access(cur_req);
        if (cur_req.typed) begin
          want.rdata = '0;
          want.st = cur_req.typed_st;
          pending_results.push_back(want);
        end else begin
          pending_results.push_back(pred);
        end
      end
      if (out_tvalid && out_tready) begin
        moved = 1'b1;
        if (pending_results.size() == 0) begin
          $error("unexpected result: read_data %h status %0d", out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata !== want.rdata) begin
            $error("read_data mismatch: expected %h, got %h", want.rdata, out_tdata);
            fail_count++;
          end
          if (out_tuser !== want.st) begin
            $error("status mismatch: expected %0d, got %0d", want.st, out_tuser);
            fail_count++;
          end
        end
      end
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int unsigned send_pcts [4];
    int unsigned rcv_pcts [4];
    send_pcts = '{0, 52, 0, 14};
    rcv_pcts  = '{0, 0, 52, 14};
    foreach (mem_image[i]) mem_image[i] = 8'h00;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0000_0000, 32'h0, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_BYTE, 32'h0000_FFFF, 32'h0, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_WORD, 32'h0000_0000, 32'hFFFF_FFFF, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0000_0000, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_BYTE, 32'h0000_0001, 32'h0000_00A5, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0000_0000, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_HALF, 32'h0000_0002, 32'h1234_5678, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_HALF, 32'h0000_0002, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_BYTE, 32'h0000_0003, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_WORD, 32'h0000_FFFC, 32'h8000_0001, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0000_FFFC, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_BYTE, 32'h0000_FFFF, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_HALF, 32'h0000_FFFE, 32'hDEAD_BEEF, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_HALF, 32'h0000_FFFE, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0001_0000, 32'h0, TYPED, ST_RANGE});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TYPED, ST_RANGE});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0001_0001, 32'h0, TYPED, ST_RANGE});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_HALF, 32'h0000_0001, 32'h0, TYPED, ST_ALIGN});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_WORD, 32'h0000_0002, 32'h5555_AAAA, TYPED, ST_ALIGN});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0000_0003, 32'h0, TYPED, ST_ALIGN});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_WORD_ALT, 32'h0000_0008, 32'hCAFE_F00D, TYPED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD_ALT, 32'h0000_0008, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD_ALT, 32'h0000_0009, 32'h0, TYPED, ST_ALIGN});
    dir_reqs.push_back(access_t'{REQ_LOAD,  SZ_WORD, 32'h0000_0008, 32'h0, PREDICTED, ST_OK});
    dir_reqs.push_back(access_t'{REQ_STORE, SZ_BYTE, 32'h0000_0000, 32'h0, TYPED, ST_OK});

    foreach (dir_reqs[i]) issue(dir_reqs[i]);

    for (int p = 0; p < 4; p++) begin
      // hold off new requests until every result is back
      drain();
      send_idle_pct = send_pcts[p];
      rcv_stall_pct = rcv_pcts[p];
      repeat (PHASE_REQS) issue(random_access());
    end

    drain();
    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
